// ----- hw/rtl/ble_pkg.sv -----
// Shared types and constants of the battery level estimator.
// Request and result structs, register indexes, level codes, discharge curve.
// No dependencies.
`default_nettype none

package ble_pkg;

	localparam int MAX_BURST_DEFAULT = 16;

	// Pin voltage scaling when no calibration is present.
	localparam int NOMINAL_FULL_MV = 3100;
	localparam int RAW_FULL_CODE   = 4095;

	// Widths of the shared arithmetic unit.
	localparam int MUL_W     = 24;
	localparam int DIV_NUM_W = 22;
	localparam int DIV_DEN_W = 10;
	localparam int DIV_CNT_W = 5;

	// Division of the scaled pin voltage by 100: quarter it, then multiply by
	// ceil(2^25 / 25) and keep the bits from 25 up.
	localparam int SCALE_RECIP = 1342178;
	localparam int SCALE_SHIFT = 25;
	localparam int SCALE_W     = 41;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 10;

	localparam logic [CFG_INDEX_W-1:0] REG_CAL_PRESENT   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DIVIDER_RATIO = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CRITICAL_PCT  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LOW_PCT       = 2'd3;

	localparam logic [1:0] LEVEL_OK       = 2'd0;
	localparam logic [1:0] LEVEL_LOW      = 2'd1;
	localparam logic [1:0] LEVEL_CRITICAL = 2'd2;

	localparam logic STATUS_UPDATED = 1'b0;
	localparam logic STATUS_FAILED  = 1'b1;

	localparam int CURVE_POINTS = 11;
	localparam logic [15:0] CURVE_MV [CURVE_POINTS] = '{
		16'd3300, 16'd3600, 16'd3700, 16'd3730, 16'd3770, 16'd3790,
		16'd3820, 16'd3870, 16'd3920, 16'd4000, 16'd4200
	};

	typedef struct packed {
		logic [11:0] raw_code;
		logic        read_ok;
		logic [11:0] cal_millivolts;
		logic        cal_ok;
		logic        burst_end;
	} item_t;

	typedef struct packed {
		logic        status;
		logic [11:0] pin_millivolts;
		logic [15:0] cell_millivolts;
		logic [6:0]  charge_percent;
		logic [1:0]  level;
		logic        level_changed;
	} result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/battery_level_estimator_unit.sv -----
// Battery level estimator: averages a burst of ADC reads, smooths the cell voltage
// and turns it into a charge percentage and a level.
// Depends on ble_pkg.
`default_nettype none

// How the block is used:
// - Requests arrive on item / item_valid / item_stall. One request is one ADC read
//   with its ok flags; burst_end marks the last read of a burst. A request is taken
//   at a clock edge with item_valid high and item_stall low.
// - One result leaves on result / result_valid / result_stall for every request
//   with burst_end set, and none for other requests. A result is taken at an edge
//   with result_valid high and result_stall low.
// - Registers are written through cfg_write / cfg_index / cfg_data, one per cycle;
//   the user writes them only while the block is idle, which it does not enforce.
// - A read that does not close a burst goes through capture, one pass through the
//   shared multiplier, then accumulation with an exact divide by 4095.
// - A read that closes a burst with usable reads runs the shared restoring divider,
//   one quotient bit a cycle over 22 bits, for the burst average and for the curve
//   interpolation; the divider-ratio scaling uses the shared multiplier, then a
//   quarter and a reciprocal multiplication by 1/25.
// - item_stall is low only while the sequencer is idle. A finished result sits in
//   the output register; the next request is taken while it waits. If the receiver
//   still stalls when the following result is ready, the sequencer holds it.
// - Reset clears the burst accumulators, the smoother and the previous level and
//   loads the register defaults. No clearing pass is needed.

module battery_level_estimator_unit #(
	parameter int MAX_BURST = ble_pkg::MAX_BURST_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_valid,
	output logic                                 item_stall,
	input  wire ble_pkg::item_t                  item,
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output ble_pkg::result_t                     result,
	input  wire logic                            cfg_write,
	input  wire logic [ble_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [ble_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ble_pkg::*;

	localparam int CW = $clog2(MAX_BURST + 1);
	localparam int SW = 12 + CW;

	// Sequencer states.
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MUL    = 4'd1;
	localparam logic [3:0] S_ACC    = 4'd2;
	localparam logic [3:0] S_DIV    = 4'd3;
	localparam logic [3:0] S_MUL2   = 4'd4;
	localparam logic [3:0] S_SMOOTH = 4'd5;
	localparam logic [3:0] S_SEG    = 4'd6;
	localparam logic [3:0] S_PCT    = 4'd7;
	localparam logic [3:0] S_FIN    = 4'd8;
	localparam logic [3:0] S_OUT    = 4'd9;
	localparam logic [3:0] S_SCALE  = 4'd10;

	// Configuration registers.
	logic       cal_present_q;
	logic [9:0] divider_ratio_q;
	logic [6:0] critical_pct_q;
	logic [6:0] low_pct_q;

	// Burst and smoother state.
	logic [SW-1:0] sum_q;
	logic [CW-1:0] taken_q;
	logic [CW-1:0] seen_q;
	logic          loaded_q;
	logic [15:0]   smooth_q;
	logic [1:0]    prev_level_q;

	// Sequencer and working registers.
	logic [3:0]           state_q;
	logic [3:0]           ret_q;
	item_t                item_q;
	logic [MUL_W-1:0]     prod_q;
	logic [11:0]          pin_q;
	logic [3:0]           seg_q;
	logic [6:0]           pct_q;
	result_t              res_q;
	logic                 result_valid_q;
	result_t              result_q;

	// Shared divider registers.
	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	// Shared multiplier.
	logic [11:0]      mul_a;
	logic [11:0]      mul_b;
	logic [MUL_W-1:0] mul_p;

	always_comb begin
		if (state_q == S_MUL2) begin
			mul_a = pin_q;
			mul_b = {2'b00, divider_ratio_q};
		end else begin
			mul_a = item_q.raw_code;
			mul_b = 12'(NOMINAL_FULL_MV);
		end
	end

	assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

	// Exact divide by 4095: the estimate x >> 12 is low by at most one, so one
	// compare of the remainder settles it.
	logic [11:0] nom_q0;
	logic [12:0] nom_rem;
	logic [11:0] nom_mv;

	assign nom_q0  = prod_q[23:12];
	assign nom_rem = {1'b0, prod_q[11:0]} + {1'b0, nom_q0};
	assign nom_mv  = (nom_rem >= 13'(RAW_FULL_CODE)) ? nom_q0 + 12'd1 : nom_q0;

	// Scaling by the divider ratio: the product pin * ratio sits in num_q and is
	// divided by 100 as a quarter followed by a reciprocal multiplication by 1/25,
	// which is exact for every product of a 12-bit pin and a 10-bit ratio.
	logic [SCALE_W-1:0] scale_prod;
	logic [15:0]        scale_mv;

	assign scale_prod = SCALE_W'(num_q[DIV_NUM_W-1:2]) * SCALE_W'(SCALE_RECIP);
	assign scale_mv   = scale_prod[SCALE_SHIFT+15:SCALE_SHIFT];

	// Accumulation of one read.
	logic          read_counts;
	logic [11:0]   read_mv;
	logic [SW-1:0] sum_next;
	logic [CW-1:0] taken_next;
	logic          seen_room;

	always_comb begin
		seen_room   = seen_q < CW'(MAX_BURST);
		read_counts = seen_room && item_q.read_ok && (!cal_present_q || item_q.cal_ok);
		read_mv     = cal_present_q ? item_q.cal_millivolts : nom_mv;
		sum_next    = sum_q;
		taken_next  = taken_q;
		if (read_counts) begin
			sum_next   = sum_q + SW'(read_mv);
			taken_next = taken_q + CW'(1);
		end
	end

	// One restoring divide step.
	logic [DIV_DEN_W:0]   div_shift;
	logic [DIV_DEN_W+1:0] div_diff;

	assign div_shift = {rem_q[DIV_DEN_W-1:0], num_q[DIV_NUM_W-1]};
	assign div_diff  = {1'b0, div_shift} - {2'b00, den_q};

	// Curve segment search over the constant break points.
	logic [3:0]           seg_k;
	logic [15:0]          seg_lo;
	logic [DIV_DEN_W-1:0] seg_span;
	logic [15:0]          seg_off;

	always_comb begin
		seg_k = 4'd10;
		for (int k = CURVE_POINTS - 1; k >= 1; k--) begin
			if (smooth_q < CURVE_MV[k]) begin
				seg_k = 4'(k);
			end
		end
		seg_lo   = CURVE_MV[seg_k - 4'd1];
		seg_span = DIV_DEN_W'(CURVE_MV[seg_k] - seg_lo);
		seg_off  = smooth_q - seg_lo;
	end

	// Level classification of the finished percentage.
	logic [1:0] level_now;

	always_comb begin
		if (pct_q <= critical_pct_q) begin
			level_now = LEVEL_CRITICAL;
		end else if (pct_q <= low_pct_q) begin
			level_now = LEVEL_LOW;
		end else begin
			level_now = LEVEL_OK;
		end
	end

	// Result words for a failed burst and for a finished reading.
	result_t res_failed;
	result_t res_done;

	always_comb begin
		res_failed                = '0;
		res_failed.status         = STATUS_FAILED;
		res_done.status           = STATUS_UPDATED;
		res_done.pin_millivolts   = pin_q;
		res_done.cell_millivolts  = smooth_q;
		res_done.charge_percent   = pct_q;
		res_done.level            = level_now;
		res_done.level_changed    = level_now != prev_level_q;
	end

	// Smoother update: a quarter of the difference, truncated toward zero.
	logic [15:0] cell_mv;
	logic [15:0] smooth_next;

	always_comb begin
		cell_mv = num_q[15:0];
		if (!loaded_q) begin
			smooth_next = cell_mv;
		end else if (cell_mv >= smooth_q) begin
			smooth_next = smooth_q + ((cell_mv - smooth_q) >> 2);
		end else begin
			smooth_next = smooth_q - ((smooth_q - cell_mv) >> 2);
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_present_q   <= 1'b0;
			divider_ratio_q <= 10'd200;
			critical_pct_q  <= 7'd5;
			low_pct_q       <= 7'd20;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_CAL_PRESENT:   cal_present_q   <= cfg_data[0];
				REG_DIVIDER_RATIO: divider_ratio_q <= cfg_data;
				REG_CRITICAL_PCT:  critical_pct_q  <= cfg_data[6:0];
				REG_LOW_PCT:       low_pct_q       <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer with its control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			ret_q          <= S_IDLE;
			sum_q          <= '0;
			taken_q        <= '0;
			seen_q         <= '0;
			loaded_q       <= 1'b0;
			smooth_q       <= '0;
			prev_level_q   <= LEVEL_OK;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// The output register loads a new result when it is empty or being
			// taken on this edge; otherwise a taken result empties it.
			if (state_q == S_OUT && (!result_valid_q || !result_stall)) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (!item_q.burst_end) begin
						if (seen_room) begin
							seen_q <= seen_q + CW'(1);
						end
						sum_q   <= sum_next;
						taken_q <= taken_next;
						state_q <= S_IDLE;
					end else begin
						// The burst closes here whatever its outcome.
						sum_q   <= '0;
						taken_q <= '0;
						seen_q  <= '0;
						if (taken_next == '0) begin
							state_q <= S_OUT;
						end else begin
							cnt_q   <= DIV_CNT_W'(DIV_NUM_W);
							ret_q   <= S_MUL2;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - DIV_CNT_W'(1);
					if (cnt_q == DIV_CNT_W'(1)) begin
						state_q <= ret_q;
					end
				end
				S_MUL2: begin
					state_q <= S_SCALE;
				end
				S_SCALE: begin
					state_q <= S_SMOOTH;
				end
				S_SMOOTH: begin
					smooth_q <= smooth_next;
					loaded_q <= 1'b1;
					state_q  <= S_SEG;
				end
				S_SEG: begin
					if (smooth_q <= CURVE_MV[0] || smooth_q >= CURVE_MV[CURVE_POINTS-1]) begin
						state_q <= S_FIN;
					end else begin
						cnt_q   <= DIV_CNT_W'(DIV_NUM_W);
						ret_q   <= S_PCT;
						state_q <= S_DIV;
					end
				end
				S_PCT: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					prev_level_q <= level_now;
					state_q      <= S_OUT;
				end
				S_OUT: begin
					if (!result_valid_q || !result_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					item_q <= item;
				end
			end
			S_MUL: begin
				prod_q <= mul_p;
			end
			S_ACC: begin
				num_q <= DIV_NUM_W'(sum_next);
				den_q <= DIV_DEN_W'(taken_next);
				rem_q <= '0;
				res_q <= res_failed;
			end
			S_DIV: begin
				if (!div_diff[DIV_DEN_W+1]) begin
					rem_q <= div_diff[DIV_DEN_W:0];
					num_q <= {num_q[DIV_NUM_W-2:0], 1'b1};
				end else begin
					rem_q <= div_shift;
					num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
				end
			end
			S_MUL2: begin
				// The burst average is in the divider's quotient.
				num_q <= mul_p[DIV_NUM_W-1:0];
			end
			S_SCALE: begin
				num_q <= DIV_NUM_W'(scale_mv);
			end
			S_SMOOTH: begin
				pin_q <= pin_q;
			end
			S_SEG: begin
				seg_q <= seg_k - 4'd1;
				num_q <= DIV_NUM_W'({seg_off, 3'b000}) + DIV_NUM_W'({seg_off, 1'b0});
				den_q <= seg_span;
				rem_q <= '0;
				if (smooth_q <= CURVE_MV[0]) begin
					pct_q <= 7'd0;
				end else begin
					pct_q <= 7'd100;
				end
			end
			S_PCT: begin
				pct_q <= 7'({seg_q, 3'b000}) + 7'({seg_q, 1'b0}) + 7'(num_q[3:0]);
			end
			S_FIN: begin
				res_q <= res_done;
			end
			S_OUT: begin
				if (!result_valid_q || !result_stall) begin
					result_q <= res_q;
				end
			end
			default: begin
			end
		endcase
		// Capture the burst average when the first divide finishes.
		if (state_q == S_DIV && cnt_q == DIV_CNT_W'(1) && ret_q == S_MUL2) begin
			pin_q <= !div_diff[DIV_DEN_W+1] ? {num_q[10:0], 1'b1} : {num_q[10:0], 1'b0};
		end
	end

	assign item_stall   = state_q != S_IDLE;
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for battery_level_estimator_unit: directed table, then random bursts.
// Results are compared against an in-bench estimator model over several register settings.
// Depends on ble_pkg and the battery_level_estimator_unit RTL.
`timescale 1ns / 1ps

module tb_top;
	import ble_pkg::*;

	localparam int BURST_LIMIT  = MAX_BURST_DEFAULT;
	// A burst close runs up to two serial 22-bit divides; the settle wait covers
	// any request still being worked on.
	localparam int SETTLE_CYCLES = 120;
	localparam int CYCLE_LIMIT   = 1000000;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;
	logic    cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Shadow copies of the registers and of the estimator state.
	int unsigned use_cal, ratio_x100, crit_pct, low_pct;
	int unsigned acc_mv_sum, acc_taken, acc_seen;
	int unsigned smooth_loaded, smooth_mv, last_pct, last_level;

	// Readings the block still owes us, oldest first.
	result_t expected_readings[$];

	// A directed table row may carry a reading typed in by hand. The driver
	// sets these along with the request so the monitor can pick them up.
	bit      row_typed;
	result_t row_reading;

	// Traffic shaping shared between the sender and the receiver.
	bit calm;
	bit hold_request;

	int mismatches;
	int cycles;

	typedef struct {
		item_t   req;
		bit      typed;
		result_t reading;
	} dir_row_t;

	dir_row_t dir_rows[$];

	battery_level_estimator_unit #(
		.MAX_BURST(BURST_LIMIT)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Estimator model
	// ------------------------------------------------------------------

	function automatic void clear_estimator();
		use_cal       = 0;
		ratio_x100    = 200;
		crit_pct      = 5;
		low_pct       = 20;
		acc_mv_sum    = 0;
		acc_taken     = 0;
		acc_seen      = 0;
		smooth_loaded = 0;
		smooth_mv     = 0;
		last_pct      = 0;
		last_level    = LEVEL_OK;
	endfunction

	// Piecewise linear state of charge on the discharge curve, truncated.
	function automatic int unsigned charge_from_mv(input int unsigned mv);
		int unsigned lo;
		int unsigned span;
		if (mv <= CURVE_MV[0])
			return 0;
		if (mv >= CURVE_MV[CURVE_POINTS-1])
			return 100;
		for (int k = 1; k < CURVE_POINTS; k++) begin
			if (mv < CURVE_MV[k]) begin
				lo   = CURVE_MV[k-1];
				span = CURVE_MV[k] - lo;
				return (k - 1) * 10 + ((mv - lo) * 10) / span;
			end
		end
		return 100;
	endfunction

	// Folds one accepted request into the model. When the request closes a
	// burst, 'closes' is set and 'reading' holds what the block must report.
	function automatic void estimate_read(input item_t req, output bit closes,
			output result_t reading);
		int unsigned mv, pin, cell_mv, pct, lvl;
		reading = '0;
		closes  = req.burst_end;
		// Reads beyond the burst limit are dropped, but their end flag still counts.
		if (acc_seen < BURST_LIMIT) begin
			acc_seen++;
			if (req.read_ok && (use_cal == 0 || req.cal_ok)) begin
				mv = use_cal ? req.cal_millivolts
					: (req.raw_code * NOMINAL_FULL_MV) / RAW_FULL_CODE;
				acc_mv_sum += mv;
				acc_taken++;
			end
		end
		if (!req.burst_end)
			return;
		if (acc_taken == 0) begin
			// Nothing usable in the burst: the smoother and the level history stay put.
			reading.status = STATUS_FAILED;
		end else begin
			pin     = acc_mv_sum / acc_taken;
			cell_mv = (pin * ratio_x100) / 100;
			if (!smooth_loaded) begin
				smooth_mv     = cell_mv;
				smooth_loaded = 1;
			end else if (cell_mv >= smooth_mv) begin
				smooth_mv += (cell_mv - smooth_mv) / 4;
			end else begin
				smooth_mv -= (smooth_mv - cell_mv) / 4;
			end
			smooth_mv &= 16'hFFFF;
			pct = charge_from_mv(smooth_mv);
			if (pct <= crit_pct)
				lvl = LEVEL_CRITICAL;
			else if (pct <= low_pct)
				lvl = LEVEL_LOW;
			else
				lvl = LEVEL_OK;
			reading.status          = STATUS_UPDATED;
			reading.pin_millivolts  = pin[11:0];
			reading.cell_millivolts = smooth_mv[15:0];
			reading.charge_percent  = pct[6:0];
			reading.level           = lvl[1:0];
			reading.level_changed   = (lvl != last_level);
			last_pct   = pct;
			last_level = lvl;
		end
		acc_mv_sum = 0;
		acc_taken  = 0;
		acc_seen   = 0;
	endfunction

	// ------------------------------------------------------------------
	// Monitor: everything is sampled at the rising edge, before the block's
	// own registers update, so the values seen are the ones the edge acts on.
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		bit      closes;
		result_t reading;
		result_t want;
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else if (arst_n) begin
			// A request taken on this edge updates the model first. The block passes each
			// request through its sequencer states, so its reading can never leave on this same edge.
			if (item_valid && !item_stall) begin
				estimate_read(item, closes, reading);
				if (closes)
					expected_readings.push_back(row_typed ? row_reading : reading);
			end
			if (result_valid && !result_stall) begin
				if (expected_readings.size() == 0) begin
					$error("result arrived with no reading expected");
					mismatches++;
				end else begin
					want = expected_readings.pop_front();
					check_field("status", want.status, result.status);
					check_field("pin_millivolts", want.pin_millivolts, result.pin_millivolts);
					check_field("cell_millivolts", want.cell_millivolts,
						result.cell_millivolts);
					check_field("charge_percent", want.charge_percent, result.charge_percent);
					check_field("level", want.level, result.level);
					check_field("level_changed", want.level_changed, result.level_changed);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: stalls at random about a fifth of the time. A hold request
	// from the main sequence makes it refuse results for a long stretch,
	// counted here, so the block's output register and sequencer fill up.
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		static int hold_cycles = 0;
		if (hold_request) begin
			hold_cycles  = 400;
			hold_request = 1'b0;
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !calm && ($urandom_range(99) < 21);
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Offers one request and returns at the falling edge after it was taken.
	// Valid stays high into the next request unless an idle gap comes first.
	task automatic send_read(input item_t req, input bit typed, input result_t reading);
		if (!calm) begin
			if ($urandom_range(99) < 3) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(10, 60)) @(negedge clk);
			end
			while ($urandom_range(99) < 21) begin
				item_valid <= 1'b0;
				@(negedge clk);
			end
		end
		item        <= req;
		item_valid  <= 1'b1;
		row_typed   = typed;
		row_reading = reading;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
	endtask

	// Stops sending and waits until every reading is back, then lets any
	// request that closes no burst finish inside the block.
	task automatic drain();
		item_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes all four registers on back-to-back cycles; the block is idle.
	task automatic write_regs(input int unsigned cal, input int unsigned div,
			input int unsigned crit, input int unsigned low);
		cfg_write <= 1'b1;
		cfg_index <= REG_CAL_PRESENT;
		cfg_data  <= CFG_DATA_W'(cal);
		use_cal    = cal & 1;
		@(negedge clk);
		cfg_index <= REG_DIVIDER_RATIO;
		cfg_data  <= CFG_DATA_W'(div);
		ratio_x100 = div & 10'h3FF;
		@(negedge clk);
		cfg_index <= REG_CRITICAL_PCT;
		cfg_data  <= CFG_DATA_W'(crit);
		crit_pct   = crit & 7'h7F;
		@(negedge clk);
		cfg_index <= REG_LOW_PCT;
		cfg_data  <= CFG_DATA_W'(low);
		low_pct    = low & 7'h7F;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// Most pin voltages are aimed so the cell lands on or near the curve at
	// the current divider; the rest span the whole ADC range.
	function automatic int unsigned pick_pin_mv();
		int unsigned pin;
		if (ratio_x100 != 0 && $urandom_range(99) < 70) begin
			pin = ($urandom_range(3200, 4300) * 100) / ratio_x100;
			return (pin > 4095) ? 4095 : pin;
		end
		return $urandom_range(0, 4095);
	endfunction

	// Random bursts until about 'target' reads that the block looks at were sent.
	// Most bursts are well formed with mostly good reads; some run past the
	// burst limit, and some are short noise with random ok flags.
	task automatic run_bursts(input int target);
		int    count;
		int    len;
		int    kind;
		int    i;
		int    cal_mv;
		int unsigned pin;
		item_t req;
		count = 0;
		while (count < target) begin
			kind = $urandom_range(99);
			if (kind < 80)
				len = $urandom_range(1, BURST_LIMIT);
			else if (kind < 88)
				len = $urandom_range(BURST_LIMIT + 1, BURST_LIMIT + 8);
			else
				len = $urandom_range(1, 6);
			for (i = 0; i < len; i++) begin
				pin = pick_pin_mv();
				if (kind >= 88) begin
					req.raw_code       = 12'($urandom_range(0, 4095));
					req.read_ok        = 1'($urandom_range(0, 1));
					req.cal_millivolts = 12'($urandom_range(0, 4095));
					req.cal_ok         = 1'($urandom_range(0, 1));
				end else begin
					if ($urandom_range(99) < 75)
						req.raw_code = ((pin * RAW_FULL_CODE) / NOMINAL_FULL_MV > 4095)
							? 12'd4095 : 12'((pin * RAW_FULL_CODE) / NOMINAL_FULL_MV);
					else
						req.raw_code = 12'($urandom_range(0, 4095));
					cal_mv = int'(pin) + int'($urandom_range(0, 40)) - 20;
					if (cal_mv < 0)
						cal_mv = 0;
					if (cal_mv > 4095)
						cal_mv = 4095;
					req.cal_millivolts = ($urandom_range(99) < 75) ? 12'(cal_mv)
						: 12'($urandom_range(0, 4095));
					req.read_ok = ($urandom_range(99) < 92);
					req.cal_ok  = ($urandom_range(99) < 90);
				end
				req.burst_end = (i == len - 1);
				send_read(req, 1'b0, '0);
				if (i < BURST_LIMIT)
					count++;
			end
		end
	endtask

	// Adds one row to the directed table.
	task automatic add_row(input int unsigned raw, input bit rok, input int unsigned cal_mv,
			input bit cok, input bit last, input bit typed, input result_t reading);
		dir_row_t row;
		row.req.raw_code       = 12'(raw);
		row.req.read_ok        = rok;
		row.req.cal_millivolts = 12'(cal_mv);
		row.req.cal_ok         = cok;
		row.req.burst_end      = last;
		row.typed              = typed;
		row.reading            = reading;
		dir_rows.push_back(row);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		result_t failed_reading;
		result_t full_reading;
		int      i;

		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		result_stall = 1'b0;
		cfg_write    = 1'b0;
		cfg_index    = REG_CAL_PRESENT;
		cfg_data     = '0;
		row_typed    = 1'b0;
		row_reading  = '0;
		calm         = 1'b0;
		hold_request = 1'b0;
		mismatches   = 0;
		cycles       = 0;
		clear_estimator();

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		failed_reading        = '0;
		failed_reading.status = STATUS_FAILED;

		// A full-scale raw code reads 3100 mV at the pin; at the reset 2:1 divider
		// the cell is 6200 mV, which loads the smoother and is past the top of
		// the curve, so the level stays ok.
		full_reading                 = '0;
		full_reading.status          = STATUS_UPDATED;
		full_reading.pin_millivolts  = 12'd3100;
		full_reading.cell_millivolts = 16'd6200;
		full_reading.charge_percent  = 7'd100;
		full_reading.level           = LEVEL_OK;
		full_reading.level_changed   = 1'b0;

		// Directed part at the reset register values.
		// A burst whose only read failed reports failure before the smoother is loaded.
		add_row(4095, 1'b0, 4095, 1'b1, 1'b1, 1'b1, failed_reading);
		// The first good burst loads the smoother directly.
		add_row(4095, 1'b1, 0, 1'b0, 1'b1, 1'b1, full_reading);
		// A zero code pulls the smoother down by a quarter step.
		add_row(0, 1'b1, 4095, 1'b1, 1'b1, 1'b0, '0);
		// A three-read burst is averaged; calibration flags are ignored here.
		add_row(2500, 1'b1, 0, 1'b0, 1'b0, 1'b0, '0);
		add_row(2600, 1'b1, 4095, 1'b1, 1'b0, 1'b0, '0);
		add_row(2700, 1'b1, 0, 1'b0, 1'b1, 1'b0, '0);
		// An overlong burst: the read after the limit is dropped but still closes it.
		for (i = 0; i < BURST_LIMIT; i++)
			add_row(2400 + 25 * i, 1'b1, 0, 1'b0, 1'b0, 1'b0, '0);
		add_row(0, 1'b1, 0, 1'b0, 1'b1, 1'b0, '0);
		// A failed burst after loading must not disturb the smoother or the level.
		add_row(0, 1'b0, 0, 1'b0, 1'b1, 1'b1, failed_reading);

		foreach (dir_rows[i])
			send_read(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].reading);

		// Random part over a series of register settings.
		drain();
		write_regs(0, 200, 5, 20);
		run_bursts(155);

		// No idling on either side for this whole phase.
		drain();
		write_regs(1, 200, 10, 30);
		calm = 1'b1;
		run_bursts(155);
		calm = 1'b0;

		drain();
		write_regs(0, 50, 0, 0);
		run_bursts(155);

		// The receiver refuses results for a long stretch while requests keep coming.
		drain();
		write_regs(1, 1000, 100, 100);
		hold_request = 1'b1;
		run_bursts(155);

		// A zero divider turns every good burst into a 0 mV cell.
		drain();
		write_regs(0, 0, 5, 20);
		run_bursts(155);

		// Thresholds above 100 always match; halfway the sender waits for every
		// reading to come back before going on.
		drain();
		write_regs(1, 1023, 127, 127);
		run_bursts(78);
		drain();
		run_bursts(78);

		// Critical threshold above the low threshold.
		drain();
		write_regs(0, 230, 40, 15);
		run_bursts(155);

		drain();
		write_regs(1, $urandom_range(150, 250), $urandom_range(0, 30), $urandom_range(10, 60));
		run_bursts(155);

		drain();
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
